// ===== src/frgcd_pkg.sv =====
// Package for the fraction reduction block.
// Holds the field widths, the reset denominator and the divider control and status types.
// No dependencies.
package frgcd_pkg;

   // denominator register and result denominator widths
   localparam int DEN_WIDTH     = 20;
   localparam int OUT_DEN_WIDTH = 21;

   // register value after reset: five decimal fraction digits
   localparam logic [DEN_WIDTH-1:0] DEFAULT_DENOMINATOR = 20'd100000;

   // divider launch: wide runs the full shift length, otherwise DEN_WIDTH bits
   typedef struct packed {
      logic start;
      logic wide;
   } div_ctrl_type;

   // divider status: done pulses for one cycle when quotient and remainder are final
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== src/fraction_reduce_gcd_core.sv =====
// Reduces a scaled numerator over the configured denominator to lowest terms.
// Depends on frgcd_pkg and frgcd_div.
//
// One word in, one word out. The block takes a numerator already scaled to csr_write_data's
// denominator (reset 100000) and returns numerator/g over denominator/g, where g comes from
// Euclid's algorithm on truncating remainders, so g and the result denominator carry the sign
// that signed integer remainder gives. A zero numerator gives 0/1, a zero denominator with a
// nonzero numerator gives 1/0. One item is in work at a time; req_stall is high from the word
// after acceptance until the result is loaded into the output register, which may still be
// waiting on rsp_stall when the next word is taken. All division runs on one bit-serial
// divider, one quotient bit per cycle. There are at most about 30 Euclid remainder steps for a
// 20-bit denominator. The zero special cases skip the divider.
module fraction_reduce_gcd_core #(
   parameter int VALUE_WIDTH = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [frgcd_pkg::DEN_WIDTH-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [VALUE_WIDTH-1:0]        req_scaled_numerator,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]        rsp_reduced_numerator,
   output logic signed [frgcd_pkg::OUT_DEN_WIDTH-1:0] rsp_reduced_denominator
);
   import frgcd_pkg::*;

   localparam int SHIFT_WIDTH = (VALUE_WIDTH > DEN_WIDTH) ? VALUE_WIDTH : DEN_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_GCD,
      S_QNUM,
      S_QDEN,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [DEN_WIDTH-1:0]       den_cfg_ff;
   logic [VALUE_WIDTH-1:0]     num_ff;
   logic [VALUE_WIDTH-1:0]     nmag_ff;
   logic                       nneg_ff;
   logic                       gneg_ff;
   logic                       b_even_ff;
   logic [SHIFT_WIDTH-1:0]     opa_ff;
   logic [DEN_WIDTH-1:0]       opb_ff;
   logic                       start_ff;
   logic                       wide_ff;
   logic [VALUE_WIDTH-1:0]     rn_work_ff;
   logic [OUT_DEN_WIDTH-1:0]   rd_work_ff;
   logic                       rsp_valid_ff;
   logic [VALUE_WIDTH-1:0]     rsp_num_ff;
   logic [OUT_DEN_WIDTH-1:0]   rsp_den_ff;

   div_ctrl_type               div_ctrl;
   div_stat_type               div_stat;
   logic [SHIFT_WIDTH-1:0]     div_quo;
   logic [DEN_WIDTH-1:0]       div_rem;

   logic [VALUE_WIDTH-1:0]     num_abs;
   logic [VALUE_WIDTH-1:0]     quo_num;
   logic [OUT_DEN_WIDTH-1:0]   quo_den;

   // magnitude of the numerator; the most negative value maps to its unsigned magnitude
   always_comb begin
      num_abs = num_ff[VALUE_WIDTH-1] ? ('0 - num_ff) : num_ff;
      quo_num = div_quo[VALUE_WIDTH-1:0];
      quo_den = {1'b0, div_quo[DEN_WIDTH-1:0]};
   end

   assign div_ctrl.start = start_ff;
   assign div_ctrl.wide  = wide_ff;

   // shared divider: Euclid remainders and both final quotients
   frgcd_div #(
      .SHIFT_WIDTH (SHIFT_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (opa_ff),
      .divisor   (opb_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sequencer. Euclid runs on magnitudes; a value at an even place in the
   // remainder sequence carries the numerator's sign, an odd one is positive.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         den_cfg_ff   <= DEFAULT_DENOMINATOR;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_write_enable) begin
            den_cfg_ff <= csr_write_data;
         end
         // output word taken and no new word loaded behind it
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  num_ff   <= req_scaled_numerator;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               nneg_ff <= num_ff[VALUE_WIDTH-1];
               nmag_ff <= num_abs;
               if (num_ff == '0) begin
                  rn_work_ff <= '0;
                  rd_work_ff <= OUT_DEN_WIDTH'(1);
                  state_ff   <= S_DONE;
               end else if (den_cfg_ff == '0) begin
                  // g is the numerator itself
                  rn_work_ff <= VALUE_WIDTH'(1);
                  rd_work_ff <= '0;
                  state_ff   <= S_DONE;
               end else begin
                  opa_ff    <= SHIFT_WIDTH'(num_abs);
                  opb_ff    <= den_cfg_ff;
                  wide_ff   <= 1'b1;
                  start_ff  <= 1'b1;
                  b_even_ff <= 1'b0;
                  state_ff  <= S_GCD;
               end
            end
            S_GCD: begin
               if (div_stat.done) begin
                  if (div_rem == '0) begin
                     // divisor is g; opb_ff keeps it for both quotients
                     gneg_ff  <= b_even_ff & nneg_ff;
                     opa_ff   <= SHIFT_WIDTH'(nmag_ff);
                     wide_ff  <= 1'b1;
                     start_ff <= 1'b1;
                     state_ff <= S_QNUM;
                  end else begin
                     opa_ff    <= SHIFT_WIDTH'(opb_ff);
                     opb_ff    <= div_rem;
                     wide_ff   <= 1'b0;
                     start_ff  <= 1'b1;
                     b_even_ff <= ~b_even_ff;
                  end
               end
            end
            S_QNUM: begin
               if (div_stat.done) begin
                  rn_work_ff <= (nneg_ff ^ gneg_ff) ? ('0 - quo_num) : quo_num;
                  opa_ff     <= SHIFT_WIDTH'(den_cfg_ff);
                  wide_ff    <= 1'b0;
                  start_ff   <= 1'b1;
                  state_ff   <= S_QDEN;
               end
            end
            S_QDEN: begin
               if (div_stat.done) begin
                  rd_work_ff <= gneg_ff ? ('0 - quo_den) : quo_den;
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               // load the output register once it is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_num_ff   <= rn_work_ff;
                  rsp_den_ff   <= rd_work_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall               = (state_ff != S_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_reduced_numerator   = rsp_num_ff;
   assign rsp_reduced_denominator = rsp_den_ff;

`ifndef SYNTHESIS
   // an accepted word always goes to preparation
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_PREP))
      else $error("accepted word not prepared");

   // a result appears only from the done state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result without finished item");

   // divider completions only while a division is awaited
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_GCD || state_ff == S_QNUM || state_ff == S_QDEN))
      else $error("unexpected divider completion");

   // the divisor handed to the divider is never zero
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (opb_ff != '0))
      else $error("division by zero launched");
`endif

endmodule

// ===== src/frgcd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Dividend up to SHIFT_WIDTH bits, divisor DEN_WIDTH bits and nonzero.
// Depends on frgcd_pkg.
module frgcd_div #(
   parameter int SHIFT_WIDTH = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  frgcd_pkg::div_ctrl_type          ctrl,
   input  logic [SHIFT_WIDTH-1:0]           dividend,
   input  logic [frgcd_pkg::DEN_WIDTH-1:0]  divisor,
   output frgcd_pkg::div_stat_type          stat,
   output logic [SHIFT_WIDTH-1:0]           quotient,
   output logic [frgcd_pkg::DEN_WIDTH-1:0]  remainder
);
   import frgcd_pkg::*;

   localparam int CNT_WIDTH = $clog2(SHIFT_WIDTH + 1);

   logic [SHIFT_WIDTH-1:0] quo_ff;
   logic [DEN_WIDTH-1:0]   rem_ff;
   logic [DEN_WIDTH-1:0]   divisor_ff;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic                   done_ff;

   logic [DEN_WIDTH:0]     trial;
   logic [DEN_WIDTH:0]     diff;
   logic                   fits;

   // next partial remainder: shift in the next dividend bit, trial subtract
   always_comb begin
      trial = {rem_ff, quo_ff[SHIFT_WIDTH-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   // iteration register: dividend bits leave the top, quotient bits enter the bottom
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            // short operands sit at the top so their first bit leads
            quo_ff     <= ctrl.wide ? dividend : (dividend << (SHIFT_WIDTH - DEN_WIDTH));
            rem_ff     <= '0;
            divisor_ff <= divisor;
            count_ff   <= ctrl.wide ? CNT_WIDTH'(SHIFT_WIDTH) : CNT_WIDTH'(DEN_WIDTH);
         end else if (count_ff != '0) begin
            rem_ff   <= fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
            quo_ff   <= {quo_ff[SHIFT_WIDTH-2:0], fits};
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_WIDTH'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = (count_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   // no launch while a division runs
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !stat.busy)
      else $error("divider started while busy");

   // a launch always begins iterating
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> stat.busy)
      else $error("divider did not start iterating");

   // done follows the last iteration
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> $past(stat.busy))
      else $error("divider done without iterating");

   // final remainder is below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (rem_ff < divisor_ff))
      else $error("divider remainder not reduced");
`endif

endmodule
